// ----- src/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the Blinn-Phong shader
// Item and result words, the queue entry, pipeline depths and fixed-point
// helpers used by the front, the queue and the back of the shader.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Incoming word: ray direction and normal in signed Q2.14, color in Q0.16.
  typedef struct packed {
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] color_r;
    logic        [15:0] color_g;
    logic        [15:0] color_b;
  } in_t;

  // Result word: saturated shade in unsigned Q2.14.
  typedef struct packed {
    logic [15:0] shade_r;
    logic [15:0] shade_g;
    logic [15:0] shade_b;
  } out_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic signed [16:0] d_x;
    logic signed [16:0] d_y;
    logic signed [16:0] d_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] color_r;
    logic        [15:0] color_g;
    logic        [15:0] color_b;
    logic        [16:0] cos_nl;
    logic               zero_len;
  } q_entry_t;

  // Data that rides alongside the specular pipeline.
  typedef struct packed {
    logic        zero_len;
    logic [16:0] base_r;
    logic [16:0] base_g;
    logic [16:0] base_b;
  } side_t;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int SQRT_BITS  = 31;
  localparam int DIV_BITS   = 19;
  localparam int POW_STAGES = 4;
  localparam int SQRT_LAT   = SQRT_BITS;
  localparam int DIV_LAT    = DIV_BITS + 1;
  localparam int SIDE_LAT   = SQRT_LAT + DIV_LAT + POW_STAGES;

  localparam logic signed [16:0] LIGHT_Q14 = -17'sd16384;
  localparam logic        [18:0] POW_CAP   = 19'h40000;
  // floor(x / 5) == (x * AMB_RECIP) >> 18 for x below 2^18
  localparam logic        [15:0] AMB_RECIP = 16'd52429;

  // Q2.14 product, floored, clamped to the power cap.
  function automatic logic [18:0] mul_q14_cap(input logic [18:0] a, input logic [18:0] b);
    logic [37:0] prod;
    logic [23:0] p;
    prod = 38'(a) * 38'(b);
    p    = prod[37:14];
    return (p > 24'(POW_CAP)) ? POW_CAP : p[18:0];
  endfunction

endpackage

// ----- src/blinn_phong_shade_top.sv -----
// ----------------------------------------------------------------------------
// blinn_phong_shade_top: two-sided Blinn-Phong point shader
// Throughput: one word per cycle; the square root (31 stages, one root bit
// per stage) and divider (20 stages: an input register, then one quotient
// bit per stage) are fully pipelined.
// Reset clears the front, queue and valid pipeline; no results follow reset.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module blinn_phong_shade_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bps_pkg::in_t  item_i,
  output logic          busy_o,
  output logic          done_o,
  output bps_pkg::out_t result_o
);
  import bps_pkg::*;

  logic     push, push_ready, deq_valid;
  q_entry_t push_entry, deq_entry;

  // Front: take a word, form light minus ray, |N.L| and the zero length flag.
  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .item_i       (item_i),
    .busy_o       (busy_o),
    .push_o       (push),
    .entry_o      (push_entry),
    .push_ready_i (push_ready)
  );

  // Queue: decouple front from back; drain one word per cycle.
  bps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (push_entry),
    .ready_o     (push_ready),
    .deq_valid_o (deq_valid),
    .deq_entry_o (deq_entry)
  );

  // Back: ambient, diffuse and specular terms, then saturate.
  bps_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (deq_valid),
    .entry_i  (deq_entry),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ----- src/bps_front.sv -----
// ----------------------------------------------------------------------------
// bps_front: input stage of the shader
// Takes a word on start, forms light minus ray, |N . L| and the zero length
// flag, and holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module bps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bps_pkg::in_t      item_i,
  output logic              busy_o,
  output logic              push_o,
  output bps_pkg::q_entry_t entry_o,
  input  logic              push_ready_i
);
  import bps_pkg::*;

  logic     fr_valid_q, fr_valid_d;
  q_entry_t fr_q, fr_d;
  logic     accept;

  assign busy_o  = fr_valid_q && !push_ready_i;
  assign accept  = start_i && !busy_o;
  assign push_o  = fr_valid_q;
  assign entry_o = fr_q;

  always_comb begin
    logic signed [17:0] sum_n;
    logic signed [17:0] abs_n;
    sum_n = 18'(item_i.normal_x) + 18'(item_i.normal_y) + 18'(item_i.normal_z);
    abs_n = (sum_n < 0) ? -sum_n : sum_n;
    fr_d.d_x      = LIGHT_Q14 - 17'(item_i.ray_dir_x);
    fr_d.d_y      = LIGHT_Q14 - 17'(item_i.ray_dir_y);
    fr_d.d_z      = LIGHT_Q14 - 17'(item_i.ray_dir_z);
    fr_d.normal_x = item_i.normal_x;
    fr_d.normal_y = item_i.normal_y;
    fr_d.normal_z = item_i.normal_z;
    fr_d.color_r  = item_i.color_r;
    fr_d.color_g  = item_i.color_g;
    fr_d.color_b  = item_i.color_b;
    fr_d.cos_nl   = abs_n[16:0];
    fr_d.zero_len = (item_i.ray_dir_x == -16'sd16384) && (item_i.ray_dir_y == -16'sd16384) &&
                    (item_i.ray_dir_z == -16'sd16384);
  end

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (push_ready_i) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q <= fr_d;
    end
  end

endmodule

// ----- src/bps_queue.sv -----
// ----------------------------------------------------------------------------
// bps_queue: short queue between front and back
// Small FIFO of classified words; the back drains one word per cycle.
// ----------------------------------------------------------------------------
module bps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bps_pkg::q_entry_t entry_i,
  output logic              ready_o,
  output logic              deq_valid_o,
  output bps_pkg::q_entry_t deq_entry_o
);
  import bps_pkg::*;

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              full, pop, push;

  assign full        = (count_q == QCNT_W'(QDEPTH));
  assign pop         = (count_q != '0);
  assign ready_o     = !full || pop;
  assign push        = push_i && ready_o;
  assign deq_valid_o = pop;
  assign deq_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("word pushed into a full queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue did not drain");

endmodule

// ----- src/bps_sqrt.sv -----
// ----------------------------------------------------------------------------
// bps_sqrt: pipelined integer square root
// One result bit per stage: root = floor(sqrt(rad * 2^28)).
// ----------------------------------------------------------------------------
module bps_sqrt (
  input  logic        clk_i,
  input  logic [32:0] rad_i,
  output logic [30:0] root_o
);
  import bps_pkg::*;

  logic [63:0] rem_q  [SQRT_BITS+1];
  logic [30:0] root_q [SQRT_BITS+1];

  assign rem_q[0]  = {3'b0, rad_i, 28'b0};
  assign root_q[0] = '0;
  assign root_o    = root_q[SQRT_BITS];

  for (genvar g = 0; g < SQRT_BITS; g++) begin : g_stage
    localparam int B = SQRT_BITS - 1 - g;
    logic [63:0] rem_d;
    logic [30:0] root_d;

    always_comb begin
      logic [63:0] trial;
      trial  = (64'(root_q[g]) << (B + 1)) + (64'd1 << (2 * B));
      rem_d  = rem_q[g];
      root_d = root_q[g];
      if (rem_q[g] >= trial) begin
        rem_d  = rem_q[g] - trial;
        root_d = root_q[g] | (31'd1 << B);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1]  <= rem_d;
      root_q[g+1] <= root_d;
    end
  end

endmodule

// ----- src/bps_div.sv -----
// ----------------------------------------------------------------------------
// bps_div: pipelined restoring divider for the half-vector cosine
// Gives min((mag * 2^14) / len, 2^18), one quotient bit per stage.
// ----------------------------------------------------------------------------
module bps_div (
  input  logic        clk_i,
  input  logic [32:0] mag_i,
  input  logic [30:0] len_i,
  output logic [18:0] quo_o
);
  import bps_pkg::*;

  logic [49:0] rem_q [DIV_BITS+1];
  logic [18:0] quo_q [DIV_BITS+1];
  logic [30:0] den_q [DIV_BITS+1];
  logic        ovf_q [DIV_BITS+1];

  // Quotient at or beyond 2^19 clamps straight to the cap.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= {3'b0, mag_i, 14'b0};
    quo_q[0] <= '0;
    den_q[0] <= len_i;
    ovf_q[0] <= ({3'b0, mag_i} >= {len_i, 5'b0});
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
    localparam int B = DIV_BITS - 1 - g;
    logic [49:0] rem_d;
    logic [18:0] quo_d;

    always_comb begin
      logic [49:0] sub;
      sub   = 50'(den_q[g]) << B;
      rem_d = rem_q[g];
      quo_d = quo_q[g];
      if (rem_q[g] >= sub) begin
        rem_d = rem_q[g] - sub;
        quo_d = quo_q[g] | (19'd1 << B);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= rem_d;
      quo_q[g+1] <= quo_d;
      den_q[g+1] <= den_q[g];
      ovf_q[g+1] <= ovf_q[g];
    end
  end

  assign quo_o = (ovf_q[DIV_BITS] || (quo_q[DIV_BITS] > POW_CAP)) ? POW_CAP : quo_q[DIV_BITS];

endmodule

// ----- src/bps_back.sv -----
// ----------------------------------------------------------------------------
// bps_back: shading pipeline
// Products, sums, square root, divide, tenth power and the final saturating
// add; takes one word every cycle and never stalls.
// ----------------------------------------------------------------------------
module bps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bps_pkg::q_entry_t entry_i,
  output logic              done_o,
  output bps_pkg::out_t     result_o
);
  import bps_pkg::*;

  // stage 1: products
  logic               v1_q;
  logic        [31:0] dsq_q [3];
  logic signed [33:0] dn_q  [3];
  logic        [10:0] amb_q [3];
  logic        [16:0] dif_q [3];
  logic               zero1_q;

  // stage 2: sums
  logic               v2_q;
  logic        [32:0] lensq_q;
  logic        [32:0] mag_q;
  side_t              side2_q;

  logic        [32:0] mag_dly_q  [SQRT_LAT];
  side_t              side_dly_q [SIDE_LAT];
  logic               v_dly_q    [SIDE_LAT];

  logic [30:0] len;
  logic [18:0] cos_nh;
  logic [18:0] p2_q, p2a_q, p2b_q, p4_q, p8_q, p10_q;

  logic        done_q;
  out_t        res_q;

  always_ff @(posedge clk_i) begin
    logic signed [16:0] d   [3];
    logic signed [15:0] n   [3];
    logic        [15:0] col [3];
    logic        [32:0] cprod;
    logic        [28:0] aprod;
    d   = '{entry_i.d_x, entry_i.d_y, entry_i.d_z};
    n   = '{entry_i.normal_x, entry_i.normal_y, entry_i.normal_z};
    col = '{entry_i.color_r, entry_i.color_g, entry_i.color_b};
    for (int i = 0; i < 3; i++) begin
      dsq_q[i] <= 32'(34'(d[i]) * 34'(d[i]));
      dn_q[i]  <= 34'(d[i]) * 34'(n[i]);
      cprod     = 33'(col[i]) * 33'(entry_i.cos_nl);
      dif_q[i] <= cprod[32:16];
      aprod     = 29'(col[i][15:3]) * 29'(AMB_RECIP);
      amb_q[i] <= aprod[28:18];
    end
    zero1_q <= entry_i.zero_len;
  end

  always_ff @(posedge clk_i) begin
    logic signed [35:0] dot;
    logic signed [35:0] adot;
    logic        [33:0] lsum;
    dot  = 36'(dn_q[0]) + 36'(dn_q[1]) + 36'(dn_q[2]);
    adot = (dot < 0) ? -dot : dot;
    lsum = 34'(dsq_q[0]) + 34'(dsq_q[1]) + 34'(dsq_q[2]);
    mag_q            <= adot[32:0];
    lensq_q          <= lsum[32:0];
    side2_q.zero_len <= zero1_q;
    side2_q.base_r   <= 17'(amb_q[0]) + dif_q[0];
    side2_q.base_g   <= 17'(amb_q[1]) + dif_q[1];
    side2_q.base_b   <= 17'(amb_q[2]) + dif_q[2];
  end

  bps_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (lensq_q),
    .root_o (len)
  );

  bps_div u_div (
    .clk_i (clk_i),
    .mag_i (mag_dly_q[SQRT_LAT-1]),
    .len_i (len),
    .quo_o (cos_nh)
  );

  // Hold side data in step with the specular pipeline.
  always_ff @(posedge clk_i) begin
    mag_dly_q[0]  <= mag_q;
    side_dly_q[0] <= side2_q;
    for (int i = 1; i < SQRT_LAT; i++) begin
      mag_dly_q[i] <= mag_dly_q[i-1];
    end
    for (int i = 1; i < SIDE_LAT; i++) begin
      side_dly_q[i] <= side_dly_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q  <= mul_q14_cap(cos_nh, cos_nh);
    p4_q  <= mul_q14_cap(p2_q, p2_q);
    p2a_q <= p2_q;
    p8_q  <= mul_q14_cap(p4_q, p4_q);
    p2b_q <= p2a_q;
    p10_q <= mul_q14_cap(p8_q, p2b_q);
  end

  always_ff @(posedge clk_i) begin
    logic [17:0] spec;
    logic [17:0] s_r, s_g, s_b;
    spec = side_dly_q[SIDE_LAT-1].zero_len ? '0 : 18'(p10_q[18:1]);
    s_r  = 18'(side_dly_q[SIDE_LAT-1].base_r) + spec;
    s_g  = 18'(side_dly_q[SIDE_LAT-1].base_g) + spec;
    s_b  = 18'(side_dly_q[SIDE_LAT-1].base_b) + spec;
    res_q.shade_r <= (s_r > 18'd65535) ? 16'hFFFF : s_r[15:0];
    res_q.shade_g <= (s_g > 18'd65535) ? 16'hFFFF : s_g[15:0];
    res_q.shade_b <= (s_b > 18'd65535) ? 16'hFFFF : s_b[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
      for (int i = 0; i < SIDE_LAT; i++) begin
        v_dly_q[i] <= 1'b0;
      end
    end else begin
      v1_q       <= valid_i;
      v2_q       <= v1_q;
      v_dly_q[0] <= v2_q;
      for (int i = 1; i < SIDE_LAT; i++) begin
        v_dly_q[i] <= v_dly_q[i-1];
      end
      done_q <= v_dly_q[SIDE_LAT-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- tb/blinn_phong_shade_top_test.sv -----
// ----------------------------------------------------------------------------
// blinn_phong_shade_top_test: shading check of the Blinn-Phong point shader
// Drives shading words through the start/busy handshake with random gaps,
// predicts each shade in fixed point and compares every strobed result
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
module blinn_phong_shade_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  // Predicts shades and holds them in arrival order.
  class shade_board;
    out_t pending[$];
    int   errors;

    function logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [63:0] cap_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = (a * b) >> 14;
      return (p > 64'd262144) ? 64'd262144 : p;
    endfunction

    function logic [63:0] specular(input in_t w);
      longint d[3];
      longint n[3];
      longint dot;
      logic [63:0] lensq, len, c, p2, p4, p8;
      d[0] = -16384 - longint'(w.ray_dir_x);
      d[1] = -16384 - longint'(w.ray_dir_y);
      d[2] = -16384 - longint'(w.ray_dir_z);
      n[0] = w.normal_x;
      n[1] = w.normal_y;
      n[2] = w.normal_z;
      lensq = 0;
      dot   = 0;
      for (int i = 0; i < 3; i++) begin
        lensq += d[i] * d[i];
        dot   += d[i] * n[i];
      end
      // zero half-vector length: no highlight
      if (lensq == 0) return 0;
      len = int_sqrt(lensq << 28);
      if (len == 0) return 0;
      if (dot < 0) dot = -dot;
      c = (64'(dot) << 14) / len;
      if (c > 64'd262144) c = 64'd262144;
      p2 = cap_mul(c, c);
      p4 = cap_mul(p2, p2);
      p8 = cap_mul(p4, p4);
      return cap_mul(p8, p2) >> 1;
    endfunction

    function logic [15:0] channel(input logic [15:0] col, input logic [63:0] cosnl,
                                  input logic [63:0] spec);
      logic [63:0] s;
      s = 64'(col) / 40 + ((64'(col) * cosnl) >> 16) + spec;
      return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void note_word(input in_t w);
      longint sumn;
      logic [63:0] cosnl, spec;
      out_t e;
      sumn  = longint'(w.normal_x) + longint'(w.normal_y) + longint'(w.normal_z);
      cosnl = (sumn < 0) ? -sumn : sumn;
      spec  = specular(w);
      e.shade_r = channel(w.color_r, cosnl, spec);
      e.shade_g = channel(w.color_g, cosnl, spec);
      e.shade_b = channel(w.color_b, cosnl, spec);
      pending.push_back(e);
    endfunction

    function void check_shade(input out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.shade_r !== e.shade_r) begin
        $error("shade_r expected %0d got %0d", e.shade_r, got.shade_r);
        errors++;
      end
      if (got.shade_g !== e.shade_g) begin
        $error("shade_g expected %0d got %0d", e.shade_g, got.shade_g);
        errors++;
      end
      if (got.shade_b !== e.shade_b) begin
        $error("shade_b expected %0d got %0d", e.shade_b, got.shade_b);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  in_t  item_i;
  out_t result_o;
  shade_board board;
  longint cycle_cnt = 0;
  bit     calm;

  blinn_phong_shade_top u_top (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Note accepted words and check strobed results on the same sampling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_word(item_i);
      if (done_o) board.check_shade(result_o);
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function logic [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hC000;       // -1.0
      3: return 16'h4000;       // +1.0
      4: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom());
    endcase
  endfunction

  function in_t rand_word();
    in_t w;
    w.ray_dir_x = pick_comp();
    w.ray_dir_y = pick_comp();
    w.ray_dir_z = pick_comp();
    w.normal_x  = pick_comp();
    w.normal_y  = pick_comp();
    w.normal_z  = pick_comp();
    w.color_r   = 16'($urandom());
    w.color_g   = 16'($urandom());
    w.color_b   = 16'($urandom());
    // sometimes aim the ray at the light so the half vector vanishes
    if ($urandom_range(0, 19) == 0) begin
      w.ray_dir_x = 16'hC000;
      w.ray_dir_y = 16'hC000;
      w.ray_dir_z = 16'hC000;
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, optionally idle afterward.
  task send_word(input in_t w);
    item_i  <= w;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      item_i  <= rand_word();
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  function in_t make_word(input logic [15:0] r, input logic [15:0] n,
                          input logic [15:0] c);
    in_t w;
    w.ray_dir_x = r; w.ray_dir_y = r; w.ray_dir_z = r;
    w.normal_x  = n; w.normal_y  = n; w.normal_z  = n;
    w.color_r   = c; w.color_g   = c; w.color_b   = c;
    return w;
  endfunction

  initial begin
    int wait_cnt;
    board     = new();
    calm      = 1'b0;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    item_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero half vector, saturation, all-zero word.
    send_word(make_word(16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(16'hC000, 16'h4000, 16'hFFFF));   // zero half vector
    send_word(make_word(16'hC000, 16'h8000, 16'hFFFF));
    send_word(make_word(16'h7FFF, 16'h7FFF, 16'hFFFF));   // saturation
    send_word(make_word(16'h8000, 16'h8000, 16'h0000));
    send_word(make_word(16'h7FFF, 16'h8000, 16'h1234));
    send_word(make_word(16'h8000, 16'h7FFF, 16'hFFFF));
    send_word(make_word(16'h4000, 16'hC000, 16'h8000));
    send_word(make_word(16'hFFFF, 16'h0001, 16'h0001));
    send_word(make_word(16'h0000, 16'h4000, 16'h0028));
    begin
      in_t w;
      w = make_word(16'h0000, 16'h0000, 16'hFFFF);
      w.normal_z = 16'h4000;            // unit normal, ray head-on
      w.ray_dir_z = 16'hC000;
      send_word(w);
      w = make_word(16'h2000, 16'hE000, 16'hAAAA);
      w.color_g = 16'h5555;
      send_word(w);
    end

    for (int i = 0; i < 750; i++) begin
      if (i >= 650) calm = 1'b1;
      send_word(rand_word());
    end
    start_i <= 1'b0;

    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (80) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (board.pending.size() != 0)
        $error("%0d shades never arrived", board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bps_pkg.sv
src/bps_front.sv
src/bps_queue.sv
src/bps_sqrt.sv
src/bps_div.sv
src/bps_back.sv
src/blinn_phong_shade_top.sv
tb/blinn_phong_shade_top_test.sv
